// File: rtl/hdu_pkg.sv
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants for the half-duplex 8N1 serial engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hdu_pkg;

  // Bit engine phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_TX_START = 4'd1;
  localparam logic [3:0] PH_TX_DATA  = 4'd2;
  localparam logic [3:0] PH_TX_LAST  = 4'd3;
  localparam logic [3:0] PH_TX_STOP  = 4'd4;
  localparam logic [3:0] PH_RX_HALF  = 4'd5;
  localparam logic [3:0] PH_RX_DATA  = 4'd6;
  localparam logic [3:0] PH_RX_LAST  = 4'd7;
  localparam logic [3:0] PH_RX_STOP  = 4'd8;

  // Register indexes on the config port
  localparam logic REG_BIT_TIME      = 1'b0;
  localparam logic REG_HALF_BIT_TIME = 1'b1;

  // Register reset values
  localparam logic [7:0] BIT_TIME_RST      = 8'd25;
  localparam logic [7:0] HALF_BIT_TIME_RST = 8'd12;

  localparam logic [7:0] TICK_MAX = 8'hFF;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [7:0] bit_time;
    logic [7:0] half_bit_time;
  } hdu_cfg_t;

  typedef struct packed {
    logic       rx_pin;
    logic       tx_start;
    logic [7:0] tx_byte;
  } hdu_in_t;

  typedef struct packed {
    logic       tx_pin;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } hdu_out_t;

endpackage

`default_nettype wire

// File: rtl/hdu_core.sv
// ----------------------------------------------------------------------------
// hdu_core
// Shared bit engine and tick timer: one tick per request, state updated
// on each accepted request, result formed in the same pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  hdu_pkg::hdu_cfg_t cfg_i,
  input  hdu_pkg::hdu_in_t  in_i,
  output hdu_pkg::hdu_out_t res_o
);
  import hdu_pkg::*;

  logic [3:0] phase_q, phase_d;
  logic [7:0] tick_q, tick_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic       tx_pend_q, tx_pend_d;
  logic       line_q, line_d;
  logic       rx_valid;
  logic [7:0] tick_inc;
  logic       bit_done;

  // Next state for one tick
  always_comb begin
    phase_d    = phase_q;
    bit_idx_d  = bit_idx_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    tx_pend_d  = tx_pend_q;
    line_d     = line_q;
    rx_valid   = 1'b0;

    tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 8'd1;
    bit_done = (tick_inc >= cfg_i.bit_time);
    tick_d   = tick_inc;

    unique case (phase_q)
      PH_IDLE: begin
        if (tx_pend_q) begin
          line_d  = 1'b0;
          tick_d  = '0;
          phase_d = PH_TX_START;
        end else if (!in_i.rx_pin) begin
          rx_shift_d = '0;
          bit_idx_d  = '0;
          tick_d     = '0;
          phase_d    = PH_RX_HALF;
        end
      end
      PH_TX_START: begin
        if (bit_done) begin
          bit_idx_d  = '0;
          line_d     = tx_shift_q[0];
          tx_shift_d = {1'b0, tx_shift_q[7:1]};
          tick_d     = '0;
          phase_d    = PH_TX_DATA;
        end
      end
      PH_TX_DATA: begin
        if (bit_idx_q != LAST_BIT) begin
          if (bit_done) begin
            tick_d     = '0;
            line_d     = tx_shift_q[0];
            tx_shift_d = {1'b0, tx_shift_q[7:1]};
            bit_idx_d  = bit_idx_q + 3'd1;
          end
        end else begin
          phase_d = PH_TX_LAST;
        end
      end
      PH_TX_LAST: begin
        if (bit_done) begin
          tick_d  = '0;
          line_d  = 1'b1;
          phase_d = PH_TX_STOP;
        end
      end
      PH_TX_STOP: begin
        if (bit_done) begin
          tx_pend_d = 1'b0;
          phase_d   = PH_IDLE;
        end
      end
      PH_RX_HALF: begin
        if (tick_inc >= cfg_i.half_bit_time) begin
          tick_d  = '0;
          phase_d = PH_RX_DATA;
        end
      end
      PH_RX_DATA: begin
        if (bit_idx_q != LAST_BIT) begin
          if (bit_done) begin
            tick_d     = '0;
            // sample into bit 6 while shifting the older bits right
            rx_shift_d = {1'b0, in_i.rx_pin, rx_shift_q[6:1]};
            bit_idx_d  = bit_idx_q + 3'd1;
          end
        end else begin
          phase_d = PH_RX_LAST;
        end
      end
      PH_RX_LAST: begin
        if (bit_done) begin
          tick_d     = '0;
          rx_shift_d = {in_i.rx_pin, rx_shift_q[6:0]};
          phase_d    = PH_RX_STOP;
        end
      end
      PH_RX_STOP: begin
        if (bit_done) begin
          rx_valid = 1'b1;
          phase_d  = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // latch a new transmit request if none pending
    if (in_i.tx_start && !tx_pend_d) begin
      tx_pend_d  = 1'b1;
      tx_shift_d = in_i.tx_byte;
    end
  end

  assign res_o.tx_pin   = line_d;
  assign res_o.tx_busy  = tx_pend_d;
  assign res_o.rx_valid = rx_valid;
  assign res_o.rx_byte  = rx_shift_d;

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_idx_q  <= '0;
      tx_shift_q <= '0;
      rx_shift_q <= '0;
      tx_pend_q  <= 1'b0;
      line_q     <= 1'b1;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_idx_q  <= bit_idx_d;
      tx_shift_q <= tx_shift_d;
      rx_shift_q <= rx_shift_d;
      tx_pend_q  <= tx_pend_d;
      line_q     <= line_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/half_duplex_soft_uart_8n1.sv
// ----------------------------------------------------------------------------
// half_duplex_soft_uart_8n1
// Half-duplex 8N1 UART with one shared bit engine and tick timer.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_axis channel is one timer tick: tdata carries the
//   sampled receive pin and the byte to send, tuser the transmit request.
//   Every tick yields exactly one result on m_axis: the transmit pin level,
//   the busy flag and the receive shift register in tdata, rx_valid in tuser.
//   The result is registered and appears in the cycle after its accept;
//   one tick per clock unless m_axis stalls; engine and timer update at once.
//   The output register frees itself in the cycle it is taken, so s_axis
//   stays ready while m_axis drains; a stall on m_axis (tready low with a
//   result held) stalls s_axis and freezes the engine, so no tick is lost.
//   Reset puts the engine idle, the timer at zero, the transmit line high,
//   and loads bit_time = 25, half_bit_time = 12.
//   APB registers: 0x0 bit_time, 0x4 half_bit_time (low 8 bits used);
//   write them only while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module half_duplex_soft_uart_8n1 (
  input  wire         clk_i,
  input  wire         rst_ni,
  // tick stream in
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,  // [0] rx_pin, [8:1] tx_byte, [15:9] zero
  input  wire         s_axis_tuser,  // [0] tx_start
  // result stream out
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [0] tx_pin, [1] tx_busy, [9:2] rx_byte
  output logic        m_axis_tuser,  // [0] rx_valid
  // config port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hdu_pkg::*;

  hdu_cfg_t   cfg_q;
  hdu_in_t    item;
  hdu_out_t   res;
  logic       accept;
  logic       cfg_wr;
  logic       out_valid_q;
  hdu_out_t   out_q;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_time      <= BIT_TIME_RST;
      cfg_q.half_bit_time <= HALF_BIT_TIME_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BIT_TIME:      cfg_q.bit_time      <= pwdata[7:0];
        REG_HALF_BIT_TIME: cfg_q.half_bit_time <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BIT_TIME:      prdata = {24'd0, cfg_q.bit_time};
      REG_HALF_BIT_TIME: prdata = {24'd0, cfg_q.half_bit_time};
      default:           prdata = '0;
    endcase
  end

  // Input unpack and handshake
  assign item.rx_pin   = s_axis_tdata[0];
  assign item.tx_byte  = s_axis_tdata[8:1];
  assign item.tx_start = s_axis_tuser;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hdu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .cfg_i  (cfg_q),
    .in_i   (item),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.rx_byte, out_q.tx_busy, out_q.tx_pin};
  assign m_axis_tuser  = out_q.rx_valid;

endmodule

`default_nettype wire
